@@ src/ece_pkg.sv @@
// ----------------------------------------------------------------------------
// Easing curve evaluator package
// Curve codes, queue entry type, fixed-point constants and the elaboration-time
// generators for the sine and exponential tables of the out-elastic curve.
// ----------------------------------------------------------------------------
package ece_pkg;

	typedef enum logic [3:0] {
		CURVE_LINEAR,
		CURVE_IN_QUAD,
		CURVE_OUT_QUAD,
		CURVE_INOUT_QUAD,
		CURVE_IN_CUBIC,
		CURVE_OUT_CUBIC,
		CURVE_INOUT_CUBIC,
		CURVE_OUT_BACK,
		CURVE_OUT_ELASTIC,
		CURVE_OUT_BOUNCE
	} curve_t;

	// One classified item waiting between the front end and the evaluator.
	typedef struct packed {
		curve_t      curve;
		logic        lo_half;
		logic [16:0] t;
	} item_t;

	localparam int unsigned QUEUE_DEPTH     = 4;
	localparam int unsigned QUEUE_AW        = 2;
	localparam int unsigned PIPE_STAGES     = 5;
	localparam int unsigned OUTSTANDING_MAX = QUEUE_DEPTH + PIPE_STAGES;

	localparam logic [16:0] ONE_Q16  = 17'd65536;
	localparam logic [16:0] HALF_Q16 = 17'd32768;
	localparam logic [16:0] C1_Q16   = 17'd111515;
	localparam logic [17:0] C3_Q16   = 18'd177051;

	localparam longint unsigned TWO_PI_Q30 = 64'd6746518852;
	localparam longint unsigned LN2_Q30    = 64'd744261118;

	localparam longint unsigned SIN_DIV [6]  = '{6, 20, 42, 72, 110, 156};
	localparam longint unsigned EXP_DIV [13] = '{1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13};

	// sin(2*pi*idx/2^tb) in Q16, by quarter-wave folding and a Taylor series in Q30.
	function automatic logic signed [17:0] sin_entry(input int unsigned idx,
		input int unsigned tb);
		longint unsigned nn;
		longint unsigned j;
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint          sum;
		logic            neg;
		nn  = 64'd1 << tb;
		j   = longint'(idx) & (nn - 64'd1);
		neg = 1'b0;
		if (j >= (nn >> 1)) begin
			neg = 1'b1;
			j   = j - (nn >> 1);
		end
		if (j > (nn >> 2))
			j = (nn >> 1) - j;
		x    = (TWO_PI_Q30 * j + (nn >> 1)) >> tb;
		x2   = (x * x) >> 30;
		term = x;
		sum  = longint'(x);
		for (int k = 1; k <= 6; k++) begin
			term = ((term * x2) >> 30) / SIN_DIV[k - 1];
			if (k[0])
				sum = sum - longint'(term);
			else
				sum = sum + longint'(term);
		end
		if (sum < 0)
			sum = 0;
		sum = longint'((longint'(unsigned'(sum)) + 64'd8192) >> 14);
		return neg ? 18'(-sum) : 18'(sum);
	endfunction

	// 2^(-k/2^tb) in Q16, by a Taylor series of exp(-k*ln2/2^tb) in Q30.
	function automatic logic [16:0] exp_entry(input int unsigned k, input int unsigned tb);
		longint unsigned nn;
		longint unsigned y;
		longint unsigned term;
		longint          sum;
		nn   = 64'd1 << tb;
		y    = (LN2_Q30 * longint'(k) + (nn >> 1)) >> tb;
		term = 64'd1 << 30;
		sum  = longint'(term);
		for (int m = 1; m <= 13; m++) begin
			term = ((term * y) >> 30) / EXP_DIV[m - 1];
			if (m[0])
				sum = sum - longint'(term);
			else
				sum = sum + longint'(term);
		end
		if (sum < 0)
			sum = 0;
		return 17'((longint'(unsigned'(sum)) + 64'd8192) >> 14);
	endfunction

endpackage

@@ src/ece_front.sv @@
// ----------------------------------------------------------------------------
// Easing front end
// Accepts input transactions, saturates progress to one and decodes the curve.
// ----------------------------------------------------------------------------
module ece_front import ece_pkg::*; (
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // [16:0] progress, rest zero
	input  logic [3:0]  s_axis_tuser,   // [3:0] curve_select
	input  logic        queue_ready,
	output logic        push,
	output item_t       push_item
);

	logic [16:0] t_sat;
	curve_t      curve;

	always_comb begin
		t_sat = (s_axis_tdata[16:0] > ONE_Q16) ? ONE_Q16 : s_axis_tdata[16:0];
		if (s_axis_tuser <= 4'(CURVE_OUT_BOUNCE))
			curve = curve_t'(s_axis_tuser);
		else
			curve = CURVE_LINEAR;
		// Out-elastic passes its endpoints through unchanged, like linear.
		if (curve == CURVE_OUT_ELASTIC && (t_sat == 17'd0 || t_sat == ONE_Q16))
			curve = CURVE_LINEAR;
	end

	assign s_axis_tready     = queue_ready;
	assign push              = s_axis_tvalid && queue_ready;
	assign push_item.curve   = curve;
	assign push_item.lo_half = (t_sat < HALF_Q16);
	assign push_item.t       = t_sat;

endmodule

@@ src/ece_queue.sv @@
// ----------------------------------------------------------------------------
// Easing item queue
// Small FIFO that decouples the front end from the evaluator pipeline.
// ----------------------------------------------------------------------------
module ece_queue import ece_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	output logic  push_ready,
	input  logic  pop,
	output logic  pop_valid,
	output item_t pop_item
);

	item_t               mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_AW:0]   count_q;

	assign push_ready = (count_q != (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_item   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

@@ src/ece_back.sv @@
// ----------------------------------------------------------------------------
// Easing evaluator pipeline
// Five-stage pipeline that computes the eased value of each queued item.
// ----------------------------------------------------------------------------
module ece_back import ece_pkg::*; #(
	parameter int unsigned TABLE_BITS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  item_t              in_item,
	output logic               in_pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [17:0] eased_value
);

	localparam int unsigned ROM_N = 1 << TABLE_BITS;
	localparam int unsigned YW    = TABLE_BITS + 2;

	// Constant tables for the out-elastic curve.
	logic signed [17:0] sin_rom [ROM_N];
	logic [16:0]        exp_rom [ROM_N];

	for (genvar g = 0; g < ROM_N; g++) begin : g_rom
		assign sin_rom[g] = sin_entry(g, TABLE_BITS);
		assign exp_rom[g] = exp_entry(g, TABLE_BITS);
	end

	logic adv;
	logic v_s1, v_s2, v_s3, v_s4;

	assign adv    = !out_valid || out_ready;
	assign in_pop = adv && in_valid;

	// ---------------- stage 1 operands ----------------
	logic [16:0]            t_in, inv;
	logic [17:0]            vv;
	logic [19:0]            t11, e10, pa;
	logic signed [20:0]     u;
	logic [15:0]            off;
	logic [18:0]            x;
	logic [17:0]            pm;
	logic [18+TABLE_BITS:0] ysum;
	logic [16+TABLE_BITS:0] ksum;
	logic [TABLE_BITS:0]    kfull;
	logic [TABLE_BITS-1:0]  k_n;
	logic [3:0]             n_n;

	always_comb begin
		t_in = in_item.t;
		inv  = 17'(ONE_Q16 - t_in);
		vv   = 18'(18'd131072 - {t_in, 1'b0});
		t11  = 20'({3'b0, t_in} * 20'd11);
		e10  = 20'({3'b0, t_in} * 20'd10);
		if (t11 < 20'd262144) begin
			u   = signed'({1'b0, t11});
			off = 16'd0;
		end else if (t11 < 20'd524288) begin
			u   = signed'({1'b0, t11}) - 21'sd393216;
			off = 16'd49152;
		end else if (t11 < 20'd655360) begin
			u   = signed'({1'b0, t11}) - 21'sd589824;
			off = 16'd61440;
		end else begin
			u   = signed'({1'b0, t11}) - 21'sd688128;
			off = 16'd64512;
		end
		case (in_item.curve)
			CURVE_IN_QUAD, CURVE_IN_CUBIC:                  x = {2'b0, t_in};
			CURVE_OUT_QUAD, CURVE_OUT_CUBIC, CURVE_OUT_BACK: x = {2'b0, inv};
			CURVE_INOUT_QUAD, CURVE_INOUT_CUBIC:
				x = in_item.lo_half ? {2'b0, t_in} : {1'b0, vv};
			CURVE_OUT_BOUNCE: x = (u < 0) ? 19'(-u) : 19'(u);
			default:          x = '0;
		endcase
		// Phase in units of one third of a turn, folded into one turn.
		pa = 20'(e10 + 20'd147456);
		if (pa >= 20'd786432)
			pm = 18'(pa - 20'd786432);
		else if (pa >= 20'd589824)
			pm = 18'(pa - 20'd589824);
		else if (pa >= 20'd393216)
			pm = 18'(pa - 20'd393216);
		else if (pa >= 20'd196608)
			pm = 18'(pa - 20'd196608);
		else
			pm = pa[17:0];
		ysum  = {1'b0, pm, {TABLE_BITS{1'b0}}} + (19+TABLE_BITS)'(98304);
		ksum  = {1'b0, e10[15:0], {TABLE_BITS{1'b0}}} + (17+TABLE_BITS)'(32768);
		kfull = ksum[16 +: TABLE_BITS+1];
		if (kfull[TABLE_BITS]) begin
			k_n = '0;
			n_n = e10[19:16] + 4'd1;
		end else begin
			k_n = kfull[TABLE_BITS-1:0];
			n_n = e10[19:16];
		end
	end

	curve_t                curve_s1, curve_s2, curve_s3, curve_s4;
	logic                  lo_s1, lo_s2, lo_s3;
	logic [16:0]           t_s1, t_s2;
	logic [18:0]           x_s1, x_s2;
	logic [15:0]           off_s1, off_s2;
	logic [YW-1:0]         y_s1;
	logic [TABLE_BITS-1:0] k_s1, k_s2;
	logic [3:0]            n_s1, n_s2, n_s3;

	// ---------------- stage 2: squares and sine index ----------------
	logic [YW+15:0]        yq;
	logic [37:0]           p2_s2;
	logic [TABLE_BITS-1:0] idx_s2;

	assign yq = {16'b0, y_s1} * (YW+16)'(43691);

	// ---------------- stage 3: cubes and table products ----------------
	logic [37:0]        m2sum, qlo, qhi, qb;
	logic [16:0]        m2;
	logic signed [17:0] s_val;
	logic               s_neg;
	logic [16:0]        s_mag;
	logic [17:0]        res3;
	logic [53:0]        p3_s3;
	logic [33:0]        mb_s3, c1m2_s3, emag_s3;
	logic [17:0]        res_s3;
	logic               neg_s3;

	always_comb begin
		m2sum = p2_s2 + 38'd32768;
		qlo   = p2_s2 + 38'd16384;
		qhi   = p2_s2 + 38'd65536;
		qb    = p2_s2 + 38'd524288;
		m2    = m2sum[32:16];
		s_val = sin_rom[idx_s2];
		s_neg = s_val[17];
		s_mag = s_neg ? 17'(-s_val) : s_val[16:0];
		case (curve_s2)
			CURVE_IN_QUAD:    res3 = m2sum[16 +: 18];
			CURVE_OUT_QUAD:   res3 = 18'({1'b0, ONE_Q16} - m2sum[16 +: 18]);
			CURVE_INOUT_QUAD:
				res3 = lo_s2 ? qlo[15 +: 18] : 18'({1'b0, ONE_Q16} - qhi[17 +: 18]);
			CURVE_OUT_BOUNCE: res3 = 18'({2'b0, off_s2} + qb[20 +: 18]);
			default:          res3 = {1'b0, t_s2};
		endcase
	end

	// ---------------- stage 4: cubic and elastic results ----------------
	logic [54:0]        c32, c30, c33;
	logic [34:0]        rnd, esum, eshift;
	logic [16:0]        r_el;
	logic [33:0]        m3sum, b1sum;
	logic [17:0]        m3;
	logic signed [19:0] res4;
	logic signed [19:0] res_s4;
	logic [35:0]        c3m3_s4;
	logic [17:0]        rb1_s4;

	always_comb begin
		c32    = {1'b0, p3_s3} + 55'h0_0000_8000_0000;
		c30    = {1'b0, p3_s3} + 55'h0_0000_2000_0000;
		c33    = {1'b0, p3_s3} + 55'h0_0001_0000_0000;
		rnd    = 35'd1 << (5'd15 + {1'b0, n_s3});
		esum   = {1'b0, emag_s3} + rnd;
		eshift = esum >> (5'd16 + {1'b0, n_s3});
		r_el   = eshift[16:0];
		m3sum  = mb_s3 + 34'd32768;
		b1sum  = c1m2_s3 + 34'd32768;
		m3     = m3sum[16 +: 18];
		case (curve_s3)
			CURVE_IN_CUBIC:  res4 = signed'({2'b0, c32[32 +: 18]});
			CURVE_OUT_CUBIC: res4 = 20'sd65536 - signed'({2'b0, c32[32 +: 18]});
			CURVE_INOUT_CUBIC:
				res4 = lo_s3 ? signed'({2'b0, c30[30 +: 18]})
				             : 20'sd65536 - signed'({2'b0, c33[33 +: 18]});
			CURVE_OUT_ELASTIC:
				res4 = neg_s3 ? 20'sd65536 - signed'({3'b0, r_el})
				              : 20'sd65536 + signed'({3'b0, r_el});
			default:         res4 = signed'({2'b0, res_s3});
		endcase
	end

	// ---------------- stage 5: out-back sum and output clamp ----------------
	logic [35:0]        c3sum;
	logic signed [19:0] res5;
	logic signed [17:0] res_clamped;

	always_comb begin
		c3sum = c3m3_s4 + 36'd32768;
		if (curve_s4 == CURVE_OUT_BACK)
			res5 = 20'sd65536 + signed'({2'b0, rb1_s4}) - signed'({1'b0, c3sum[16 +: 19]});
		else
			res5 = res_s4;
		if (res5 > 20'sd131071)
			res_clamped = 18'sd131071;
		else if (res5 < -20'sd131072)
			res_clamped = -18'sd131072;
		else
			res_clamped = res5[17:0];
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (adv) begin
			curve_s1 <= in_item.curve;
			lo_s1    <= in_item.lo_half;
			t_s1     <= t_in;
			x_s1     <= x;
			off_s1   <= off;
			y_s1     <= ysum[16 +: YW];
			k_s1     <= k_n;
			n_s1     <= n_n;

			curve_s2 <= curve_s1;
			lo_s2    <= lo_s1;
			t_s2     <= t_s1;
			x_s2     <= x_s1;
			off_s2   <= off_s1;
			k_s2     <= k_s1;
			n_s2     <= n_s1;
			p2_s2    <= 38'(x_s1 * x_s1);
			idx_s2   <= yq[17 +: TABLE_BITS];

			curve_s3 <= curve_s2;
			lo_s3    <= lo_s2;
			n_s3     <= n_s2;
			res_s3   <= res3;
			neg_s3   <= s_neg;
			p3_s3    <= 54'(p2_s2[35:0] * x_s2[17:0]);
			mb_s3    <= 34'(m2 * x_s2[16:0]);
			c1m2_s3  <= 34'(m2 * C1_Q16);
			emag_s3  <= 34'(exp_rom[k_s2] * s_mag);

			curve_s4 <= curve_s3;
			res_s4   <= res4;
			c3m3_s4  <= 36'(m3 * C3_Q16);
			rb1_s4   <= b1sum[16 +: 18];

			eased_value <= res_clamped;
		end
	end

	// Stage valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			v_s4      <= 1'b0;
			out_valid <= 1'b0;
		end else if (adv) begin
			v_s1      <= in_valid;
			v_s2      <= v_s1;
			v_s3      <= v_s2;
			v_s4      <= v_s3;
			out_valid <= v_s4;
		end
	end

endmodule

@@ src/easing_curve_evaluator.sv @@
// ----------------------------------------------------------------------------
// Easing curve evaluator
// Evaluates Penner easing curves on an unsigned Q1.16 progress value, one per cycle while the output is not held.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Payload
// s_axis    in         tuser = curve_select[3:0], tdata = progress[16:0]
// m_axis    out        tdata = eased_value[17:0] (signed Q1.16)
//
// The block accepts one transaction per cycle and returns one per cycle while
// the output is not held; the evaluator is a five-stage pipeline. An input
// transaction is written into the queue, then passes pipeline stages one to
// four and then the output register. The asynchronous reset empties the queue
// and the pipeline. When the output is held by the consumer, the pipeline
// freezes and the four-entry queue keeps taking input until it is full.
//
// The front end saturates progress and decodes the curve into a queue entry.
// The evaluator squares and cubes one shared operand per item, reads the sine
// and exponential tables for out-elastic and combines the terms per curve.
// Unknown curve selectors, and out-elastic at exactly zero and one, return the
// saturated progress unchanged.
module easing_curve_evaluator import ece_pkg::*; #(
	parameter int unsigned TABLE_BITS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // [16:0] progress, [23:17] zero
	input  logic [3:0]  s_axis_tuser,   // [3:0] curve_select
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata    // [17:0] eased_value, [23:18] zero
);

	logic               push;
	logic               push_ready;
	item_t              push_item;
	logic               pop;
	logic               pop_valid;
	item_t              pop_item;
	logic signed [17:0] eased_value;

	// Front end: saturation and curve decode.
	ece_front u_front (
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.queue_ready   (push_ready),
		.push          (push),
		.push_item     (push_item)
	);

	// Queue between the two halves so each can stall on its own.
	ece_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.push_ready (push_ready),
		.pop        (pop),
		.pop_valid  (pop_valid),
		.pop_item   (pop_item)
	);

	// Evaluator pipeline with its output register.
	ece_back #(
		.TABLE_BITS (TABLE_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (pop_valid),
		.in_item     (pop_item),
		.in_pop      (pop),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.eased_value (eased_value)
	);

	assign m_axis_tdata = {6'b0, eased_value};

endmodule

@@ src/ece_checker.sv @@
// ----------------------------------------------------------------------------
// Easing evaluator port checker
// Watches the top-level ports for output stability and transaction accounting.
// ----------------------------------------------------------------------------
module ece_checker import ece_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [23:0] m_axis_tdata
);

	logic [3:0] outstanding_q;
	logic       in_acc;
	logic       out_acc;

	assign in_acc  = s_axis_tvalid && s_axis_tready;
	assign out_acc = m_axis_tvalid && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			outstanding_q <= '0;
		else if (in_acc && !out_acc)
			outstanding_q <= outstanding_q + 4'd1;
		else if (out_acc && !in_acc)
			outstanding_q <= outstanding_q - 4'd1;
	end

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result changed");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[23:18] == 6'd0)
		else $error("result padding not zero");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> outstanding_q != 4'd0)
		else $error("result without an accepted input");

	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		outstanding_q <= 4'(OUTSTANDING_MAX))
		else $error("more items in flight than the block can hold");

endmodule

bind easing_curve_evaluator ece_checker u_ece_checker (.*);
